>>> src/seed_to_permutation16_assert.svh
// Assertion macros for the seed_to_permutation16 top module.
// Expects clk and rst to be visible at the point of use.
`ifndef SEED_TO_PERMUTATION16_ASSERT_SVH
`define SEED_TO_PERMUTATION16_ASSERT_SVH

// Same-cycle implication.
`define STP16_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STP16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/stp16_pkg.sv
// Shared constants, types and controller/datapath command structs
// for seed_to_permutation16. No dependencies.
package stp16_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int ENTRY_W     = 4;
  localparam int SEED_W      = 64;
  localparam int PERM_W      = NUM_ENTRIES * ENTRY_W;
  localparam int RADIX_W     = 5;                    // holds 16 down to 2
  localparam int PROD_W      = 2 * ENTRY_W;          // {rem, nibble} and radix*digit
  localparam int NIB_PER_SEED = SEED_W / ENTRY_W;
  localparam int NIB_CNT_W   = $clog2(NIB_PER_SEED);

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic load;    // take new seed, reset permutation to identity
    logic div;     // consume one seed nibble in the divider
    logic finish;  // last nibble of this radix: swap + rotate, next radix
    logic emit;    // final rotate into the output register
  } stp16_cmd_t;

  typedef struct packed {
    logic last_digit;  // current radix is 2
  } stp16_stat_t;

endpackage

>>> src/stp16_seed_if.sv
// Input channel: valid/ready handshake carrying one 64-bit seed.
// Depends on stp16_pkg.
interface stp16_seed_if import stp16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SEED_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

>>> src/stp16_perm_if.sv
// Output channel: valid/ready handshake carrying one packed permutation.
// Depends on stp16_pkg.
interface stp16_perm_if import stp16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PERM_W-1:0] permutation;

  modport source (output valid, output permutation, input ready);
  modport sink   (input valid, input permutation, output ready);
endinterface

>>> src/stp16_dp.sv
// Datapath: nibble-serial divider by the current radix, permutation lanes
// with swap-and-rotate, output register. Depends on stp16_pkg.
module stp16_dp import stp16_pkg::*; (
  input  logic              clk,
  input  stp16_cmd_t        cmd,
  input  logic [SEED_W-1:0] seed,
  output stp16_stat_t       stat,
  output logic [PERM_W-1:0] permutation
);

  logic [SEED_W-1:0]      seed_q;
  logic [ENTRY_W-1:0]     rem;
  logic [RADIX_W-1:0]     radix;
  entry_t                 lane [NUM_ENTRIES];

  logic [PROD_W-1:0]      dividend;
  logic [NUM_ENTRIES-1:1] ge;
  logic [ENTRY_W-1:0]     qdig;
  logic [ENTRY_W-1:0]     rem_next;
  entry_t                 swapped [NUM_ENTRIES];
  entry_t                 rotated [NUM_ENTRIES];

  // one radix-16 long-division step: rem < radix, so quotient digit < 16
  assign dividend = {rem, seed_q[SEED_W-1 -: ENTRY_W]};

  always_comb begin
    for (int k = 1; k < NUM_ENTRIES; k++) begin
      ge[k] = dividend >= (PROD_W'(radix) * PROD_W'(k));
    end
  end

  assign qdig     = ENTRY_W'($countones(ge));
  assign rem_next = ENTRY_W'(dividend - (PROD_W'(radix) * PROD_W'(qdig)));

  // lane 0 is always the current base entry; swap it with lane[digit]
  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      swapped[k] = (ENTRY_W'(k) == rem_next) ? lane[0] : lane[k];
    end
    swapped[0] = lane[rem_next];
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      rotated[k] = swapped[ENTRY_W'(k + 1)];
    end
  end

  assign stat.last_digit = (radix == RADIX_W'(2));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seed_q <= seed;
      rem    <= '0;
      radix  <= RADIX_W'(NUM_ENTRIES);
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        lane[k] <= ENTRY_W'(k);
      end
    end else if (cmd.div) begin
      seed_q <= {seed_q[SEED_W-ENTRY_W-1:0], qdig};
      if (cmd.finish) begin
        rem   <= '0;
        radix <= radix - 1'b1;
        lane  <= rotated;
      end else begin
        rem <= rem_next;
      end
    end
    // one more rotation puts finished entries back in index order
    if (cmd.emit) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        permutation[ENTRY_W*k +: ENTRY_W] <= lane[ENTRY_W'(k + 1)];
      end
    end
  end

endmodule

>>> src/stp16_ctrl.sv
// Controller FSM: handshakes, nibble counter, datapath commands.
// Depends on stp16_pkg.
module stp16_ctrl import stp16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  stp16_stat_t stat,
  output stp16_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROT
  } state_t;

  localparam logic [NIB_CNT_W-1:0] NIB_LAST = NIB_CNT_W'(NIB_PER_SEED - 1);

  state_t               state;
  logic [NIB_CNT_W-1:0] nib_cnt;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = (state == ST_IDLE) && in_valid;
  assign cmd.div    = (state == ST_DIV);
  assign cmd.finish = (state == ST_DIV) && (nib_cnt == NIB_LAST);
  assign cmd.emit   = (state == ST_ROT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nib_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            nib_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          nib_cnt <= nib_cnt + 1'b1;
          if (cmd.finish && stat.last_digit) begin
            state <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (cmd.emit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/seed_to_permutation16.sv
// seed_to_permutation16 top: factorial-base unranking of a 64-bit seed into a 16x4 s-box.
// Each seed passes through the radix-16 divider once per radix, 16 down to 2, then one final
// rotate; a new seed is accepted only after the previous result is in the output register.
// The divider consumes one seed nibble per cycle; the swap rides on each radix's last nibble.
// rst (sync, active high) idles the FSM and drops result valid; datapath regs are not reset.
// Depends on stp16_pkg, stp16_seed_if, stp16_perm_if, stp16_ctrl, stp16_dp, assert macros.
`include "seed_to_permutation16_assert.svh"

module seed_to_permutation16 import stp16_pkg::*; (
  input logic          clk,
  input logic          rst,
  stp16_seed_if.sink   req,
  stp16_perm_if.source rsp
);

  // Command/status between controller and datapath:
  //   load   - seed transaction accepted; datapath copies the seed, lanes go identity
  //   div    - one long-division nibble step by the current radix
  //   finish - last nibble: remainder is the digit, swap lane 0 with lane[digit],
  //            rotate left so the next base lands in lane 0, decrement radix
  //   emit   - output register free: rotate once more into index order and present
  stp16_cmd_t  cmd;
  stp16_stat_t stat;

  stp16_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The output register is separate from the working lanes, so a new seed
  // can be loaded and worked on while the previous result waits downstream.
  stp16_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .seed        (req.seed),
    .stat        (stat),
    .permutation (rsp.permutation)
  );

  // The load, div and emit commands never overlap (finish rides on div).
  `STP16_ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.div, cmd.emit}),
                     "overlapping datapath commands")
  // A fresh seed always starts at radix 16, never at the last digit.
  `STP16_ASSERT_NEXT(a_load_full_radix, cmd.load, !stat.last_digit,
                     "radix not reloaded on seed load")
  // A pending result is never overwritten before its transaction.
  `STP16_ASSERT_IMPL(a_no_overwrite, cmd.emit, !rsp.valid || rsp.ready,
                     "result overwritten while pending")
  // No second seed is taken while one is in flight.
  `STP16_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
                     "seed accepted while busy")

endmodule

>>> tb/sv/seed_to_permutation16_checker.sv
// Checker for seed_to_permutation16: watches both channels and predicts each s-box.
// Compares every result transaction with the oldest prediction and counts failures.
// Depends on stp16_pkg, stp16_seed_if and stp16_perm_if.
module seed_to_permutation16_checker import stp16_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  stp16_seed_if  seed_ch,
  stp16_perm_if  perm_ch,
  output int     fail_count,
  output int     pending
);

  logic [PERM_W-1:0] expected_boxes[$];
  int                mismatches;

  // Factorial-base unranking: one swap per radix, 16 down to 2.
  function automatic logic [PERM_W-1:0] unrank_sbox(logic [SEED_W-1:0] rank);
    entry_t            box[NUM_ENTRIES];
    entry_t            held;
    logic [PERM_W-1:0] word;
    int                slot;
    int                pick;
    for (int k = 0; k < NUM_ENTRIES; k++) box[k] = entry_t'(k);
    for (int radix = NUM_ENTRIES; radix > 1; radix--) begin
      slot      = NUM_ENTRIES - radix;
      pick      = (slot + int'(rank % SEED_W'(radix))) % NUM_ENTRIES;
      held      = box[pick];
      box[pick] = box[slot];
      box[slot] = held;
      rank      = rank / SEED_W'(radix);
    end
    word = '0;
    for (int k = 0; k < NUM_ENTRIES; k++) word[k*ENTRY_W +: ENTRY_W] = box[k];
    return word;
  endfunction

  task automatic report_mismatch(string what, logic [PERM_W-1:0] want,
                                 logic [PERM_W-1:0] got);
    mismatches++;
    fail_count++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin : watch
    logic [PERM_W-1:0] want;
    if (!rst) begin
      // result first: it can never belong to a seed taken at this same edge
      if (perm_ch.valid && perm_ch.ready) begin
        if (expected_boxes.size() == 0) begin
          report_mismatch("permutation with no seed pending", '0, perm_ch.permutation);
        end else begin
          want = expected_boxes.pop_front();
          if (perm_ch.permutation !== want)
            report_mismatch("permutation", want, perm_ch.permutation);
        end
      end
      if (seed_ch.valid && seed_ch.ready)
        expected_boxes.push_back(unrank_sbox(seed_ch.seed));
      pending = expected_boxes.size();
    end
  end

endmodule

>>> tb/sv/seed_to_permutation16_tb.sv
// Testbench top for seed_to_permutation16: drives seeds, stalls the result side and
// gives the verdict. Depends on stp16_pkg, both channel interfaces, the block and
// seed_to_permutation16_checker.
module seed_to_permutation16_tb;
  import stp16_pkg::*;

  localparam int                NUM_SEEDS  = 1750;
  localparam int                CALM_TAIL  = 200;   // last seeds run with no idling
  localparam int                STALL_CAP  = 2000;  // cycles with no transaction
  localparam int                DRAIN_WAIT = 300;   // > one full unranking pass
  localparam logic [SEED_W-1:0] FACT16     = 64'd20922789888000;
  localparam int unsigned       MAX_WRAPS  = 881656; // FACT16 multiples that still fit

  logic clk;
  logic rst;
  bit   calm;        // no idling on either side while set
  int   fail_count;
  int   pending;
  int   sent;

  stp16_seed_if seed_ch();
  stp16_perm_if perm_ch();

  seed_to_permutation16 i_dut (
    .clk (clk),
    .rst (rst),
    .req (seed_ch),
    .rsp (perm_ch)
  );

  seed_to_permutation16_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .seed_ch    (seed_ch),
    .perm_ch    (perm_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Directed seeds: identity, single swaps at the first radixes, the top of the
  // factorial range and the wrap just past it, the 64-bit extremes, a seed whose only
  // nonzero digit is the last one (radix 2), and bit patterns.
  logic [SEED_W-1:0] directed_seeds[$] = '{
    64'd0,
    64'd1,                        // radix 16 digit 1: swap entries 0 and 1
    64'd15,                       // radix 16 digit 15: swap entries 0 and 15
    64'd16,                       // radix 15 digit 1
    64'd239,                      // first two digits at their maximum
    64'd10461394944000,           // 16!/2: only the radix-2 digit set
    FACT16 - 64'd1,               // every digit at its maximum
    FACT16,                       // wraps back to identity
    FACT16 + 64'd1,
    FACT16 * 64'd881657,          // largest multiple of 16! that fits
    64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF - FACT16,
    64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'h0123_4567_89AB_CDEF,
    64'd1307674368000             // 15!
  };

  // Random seed: raw 64-bit values (mostly wrapping), values below 16!, or seeds
  // built digit by digit with the digits pushed toward 0 and radix-1, some plus a multiple of 16!.
  function automatic logic [SEED_W-1:0] random_rank();
    logic [SEED_W-1:0] rank;
    int unsigned       mode;
    int unsigned       digit;
    mode = $urandom_range(0, 9);
    rank = {$urandom, $urandom};
    if (mode < 4) return rank;
    if (mode < 7) return rank % FACT16;
    rank = '0;
    // Horner form: radix 16 ends up as the lowest digit, radix 2 as the highest
    for (int radix = 2; radix <= NUM_ENTRIES; radix++) begin
      case ($urandom_range(0, 3))
        0: begin
          digit = 0;
        end
        1: begin
          digit = radix - 1;
        end
        default: begin
          digit = $urandom_range(0, radix - 1);
        end
      endcase
      rank = rank * SEED_W'(radix) + SEED_W'(digit);
    end
    if (mode == 9) rank += FACT16 * SEED_W'($urandom_range(0, MAX_WRAPS));
    return rank;
  endfunction

  // One seed transaction, optionally preceded by an idle burst. Called at a
  // falling edge and returns at the falling edge after acceptance.
  task automatic send_seed(input logic [SEED_W-1:0] rank);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      seed_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    seed_ch.valid <= 1'b1;
    seed_ch.seed  <= rank;
    do @(posedge clk); while (!seed_ch.ready);
    @(negedge clk);
  endtask

  // Result side: random back-pressure bursts, none started while calm or in reset.
  initial begin : result_stall
    int stall_left;
    stall_left    = 0;
    perm_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        perm_ch.ready <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 9) == 0) begin
        stall_left    = $urandom_range(1, 11) - 1;
        perm_ch.ready <= 1'b0;
      end else begin
        perm_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any cycle with a transaction on either channel restarts the count.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_CAP) begin
      @(posedge clk);
      if ((seed_ch.valid && seed_ch.ready) || (perm_ch.valid && perm_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("seed_to_permutation16_tb failed");
    $finish;
  end

  initial begin : stimulus
    rst           = 1'b1;
    calm          = 1'b0;
    sent          = 0;
    seed_ch.valid = 1'b0;
    seed_ch.seed  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_seeds[i]) begin
      send_seed(directed_seeds[i]);
      sent++;
    end

    while (sent < NUM_SEEDS) begin
      // stretches of calm now and then; always calm near the end
      if (sent % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (sent >= NUM_SEEDS - CALM_TAIL) calm = 1'b1;
      send_seed(random_rank());
      sent++;
    end
    seed_ch.valid <= 1'b0;

    // drain every prediction, then watch a while longer for strays
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (fail_count == 0)
      $display("seed_to_permutation16_tb passed");
    else
      $display("seed_to_permutation16_tb failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/stp16_pkg.sv
src/stp16_seed_if.sv
src/stp16_perm_if.sv
src/stp16_dp.sv
src/stp16_ctrl.sv
src/seed_to_permutation16.sv
tb/sv/seed_to_permutation16_checker.sv
tb/sv/seed_to_permutation16_tb.sv
